>>> rtl/oqt_pkg.sv
// oqt_pkg: shared types and constants of the occlusion query table
// action and status codes, field widths and the scan unit result struct
// no dependencies
package oqt_pkg;

   // default size of the slot pool
   localparam int NUM_SLOTS_DEFAULT = 16;
   // ids are four bits wide, so at most sixteen slots can be handed out
   localparam int MAX_IDS           = 16;

   // field widths
   localparam int ACTION_W = 3;
   localparam int QID_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int SAMPLE_W = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic [ACTION_W-1:0] ACT_ALLOC      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE     = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_IS_QUERY   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_BEGIN      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_END        = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_GET_RESULT = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_ADD        = 3'd6;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOROOM = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDEF  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTIN  = 2'd3;

   // what the scan unit reports about the free slots around the scan index
   typedef struct packed {
      logic free_here;
      logic free_above;
      logic any_free;
   } scan_info_type;

endpackage

>>> rtl/oqt_ram.sv
// oqt_ram: generic single write port, single read port RAM
// read data is registered; contents are undefined until written
// no dependencies
module oqt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/oqt_scan.sv
// oqt_scan: free slot scan unit shared by every step of an allocation
// looks at one slot index per cycle, unless a grant waits on the output,
// and tells whether free slots lie above it; depends on oqt_pkg
module oqt_scan #(
   parameter int LIMIT = 16
) (
   input  logic [LIMIT-1:0]         free_vec,
   input  logic [$clog2(LIMIT)-1:0] idx,
   output oqt_pkg::scan_info_type   info
);

   logic [LIMIT-1:0] above_mask;

   // slots strictly above the scan index
   always_comb begin
      for (int j = 0; j < LIMIT; j++) begin
         above_mask[j] = (j > int'(idx));
      end
   end

   assign info.free_here  = free_vec[idx];
   assign info.free_above = |(free_vec & above_mask);
   assign info.any_free   = |free_vec;

endmodule

>>> rtl/occlusion_query_table.sv
// occlusion_query_table: pool of occlusion query slots with one active query
// sequencer, slot valid bits, active query registers and the sample counter
// depends on oqt_pkg, oqt_scan, oqt_ram
//
//   channel | direction | tdata (low bit up)                       | tuser        | tlast
//   req_    | in        | query_id[3:0] count[8:4] sample_cnt[16:9] | action[2:0]  | -
//   rsp_    | out       | result_id[3:0] result_value[35:4] exists  | status[1:0]  | last
//
// a command is accepted in the idle state and executed in the exec state, and no new
// command is taken until it is done; an alloc that grants ids then steps through
// each slot from zero up to the slot of its final id, granted or skipped, and gives
// one result per id
// the count store needs no clearing pass after reset: every slot is zeroed when
// it is allocated; reset clears valid bits, active query and sample counter
// a full output register stalls execution until rsp_tready takes the transfer
module occlusion_query_table #(
   parameter int NUM_SLOTS = oqt_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // query_id[3:0], count[8:4], sample_count[16:9]
   input  logic [2:0]  req_tuser,  // action[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // result_id[3:0], result_value[35:4], exists[36]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   output logic        rsp_tlast
);

   localparam int LIMIT  = (NUM_SLOTS < oqt_pkg::MAX_IDS) ? NUM_SLOTS : oqt_pkg::MAX_IDS;
   localparam int IDX_W  = $clog2(LIMIT);
   localparam int SLOT_W = $clog2(NUM_SLOTS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   // sequencer and latched command
   logic [1:0]                     state_ff, state_in;
   logic [oqt_pkg::ACTION_W-1:0]   act_ff, act_in;
   logic [oqt_pkg::QID_W-1:0]      qid_ff, qid_in;
   logic [oqt_pkg::COUNT_W-1:0]    want_ff, want_in;
   logic [oqt_pkg::SAMPLE_W-1:0]   samp_ff, samp_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [oqt_pkg::COUNT_W-1:0]    granted_ff, granted_in;

   // pool state
   logic [NUM_SLOTS-1:0]           valid_ff, valid_in;
   logic                           active_valid_ff, active_valid_in;
   logic [SLOT_W-1:0]              active_slot_ff, active_slot_in;
   logic [oqt_pkg::VALUE_W-1:0]    running_ff, running_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [oqt_pkg::QID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [oqt_pkg::VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                           rsp_exists_ff, rsp_exists_in;
   logic [oqt_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                           rsp_last_ff, rsp_last_in;

   // count store ports
   logic                           ram_wr_en;
   logic [SLOT_W-1:0]              ram_wr_addr;
   logic [oqt_pkg::VALUE_W-1:0]    ram_wr_data;
   logic                           ram_rd_en;
   logic [SLOT_W-1:0]              ram_rd_addr;
   logic [oqt_pkg::VALUE_W-1:0]    ram_rd_data;

   logic                           req_xfer;
   logic                           out_free;
   logic                           in_range;
   logic [SLOT_W-1:0]              q_slot;
   logic                           ex;
   logic [oqt_pkg::COUNT_W-1:0]    granted_next;
   logic                           grant_last;
   logic [LIMIT-1:0]               free_vec;
   oqt_pkg::scan_info_type         scan_info;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // lookups for the latched command
   assign in_range     = (int'(qid_ff) < NUM_SLOTS);
   assign q_slot       = SLOT_W'(qid_ff);
   assign ex           = in_range && valid_ff[q_slot];
   assign free_vec     = ~valid_ff[LIMIT-1:0];
   assign granted_next = granted_ff + oqt_pkg::COUNT_W'(1);
   assign grant_last   = (granted_next == want_ff) || !scan_info.free_above;

   oqt_scan #(
      .LIMIT (LIMIT)
   ) u_scan (
      .free_vec (free_vec),
      .idx      (idx_ff),
      .info     (scan_info)
   );

   // count store is read on the command transfer, ready for execution
   assign ram_rd_en   = req_xfer;
   assign ram_rd_addr = SLOT_W'(req_tdata[3:0]);

   oqt_ram #(
      .WIDTH (oqt_pkg::VALUE_W),
      .DEPTH (NUM_SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      qid_in          = qid_ff;
      want_in         = want_ff;
      samp_in         = samp_ff;
      idx_in          = idx_ff;
      granted_in      = granted_ff;
      valid_in        = valid_ff;
      active_valid_in = active_valid_ff;
      active_slot_in  = active_slot_ff;
      running_in      = running_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_id_in       = rsp_id_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_exists_in   = rsp_exists_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = q_slot;
      ram_wr_data     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               act_in   = req_tuser;
               qid_in   = req_tdata[3:0];
               want_in  = req_tdata[8:4];
               samp_in  = req_tdata[16:9];
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (act_ff == oqt_pkg::ACT_ALLOC && want_ff != '0 && scan_info.any_free) begin
               // start the scan at the lowest slot
               idx_in     = '0;
               granted_in = '0;
               state_in   = S_SCAN;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_value_in  = '0;
               rsp_exists_in = 1'b0;
               rsp_status_in = oqt_pkg::ST_OK;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
               unique case (act_ff)
                  oqt_pkg::ACT_ALLOC: begin
                     // zero count gives an empty ok result, else the pool is full
                     if (want_ff != '0) begin
                        rsp_status_in = oqt_pkg::ST_NOROOM;
                     end
                  end
                  oqt_pkg::ACT_DELETE: begin
                     if (ex) begin
                        if (active_valid_ff && active_slot_ff == q_slot) begin
                           active_valid_in = 1'b0;
                           active_slot_in  = '0;
                        end
                        valid_in[q_slot] = 1'b0;
                        rsp_exists_in    = 1'b1;
                     end else begin
                        rsp_status_in = oqt_pkg::ST_UNDEF;
                     end
                  end
                  oqt_pkg::ACT_IS_QUERY: begin
                     rsp_exists_in = ex;
                  end
                  oqt_pkg::ACT_BEGIN: begin
                     running_in = '0;
                     if (ex) begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = q_slot;
                        active_valid_in = 1'b1;
                        active_slot_in  = q_slot;
                        rsp_exists_in   = 1'b1;
                     end else begin
                        rsp_status_in = oqt_pkg::ST_UNDEF;
                     end
                  end
                  oqt_pkg::ACT_END: begin
                     rsp_exists_in = ex;
                     if (active_valid_ff) begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = active_slot_ff;
                        ram_wr_data     = running_ff;
                        active_valid_in = 1'b0;
                        active_slot_in  = '0;
                     end else begin
                        rsp_status_in = oqt_pkg::ST_NOTIN;
                     end
                  end
                  oqt_pkg::ACT_GET_RESULT: begin
                     if (ex) begin
                        rsp_value_in  = ram_rd_data;
                        rsp_exists_in = 1'b1;
                     end else begin
                        rsp_status_in = oqt_pkg::ST_UNDEF;
                     end
                  end
                  oqt_pkg::ACT_ADD: begin
                     running_in    = running_ff + oqt_pkg::VALUE_W'(samp_ff);
                     rsp_exists_in = ex;
                  end
                  default: begin
                     // unused code: empty ok result
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (!scan_info.free_here) begin
               // a free slot lies further up, step over this one
               idx_in = IDX_W'(idx_ff + 1'b1);
            end else if (out_free) begin
               // grant this slot and zero its count
               valid_in[SLOT_W'(idx_ff)] = 1'b1;
               ram_wr_en     = 1'b1;
               ram_wr_addr   = SLOT_W'(idx_ff);
               rsp_valid_in  = 1'b1;
               rsp_id_in     = oqt_pkg::QID_W'(idx_ff);
               rsp_value_in  = '0;
               rsp_exists_in = 1'b1;
               rsp_last_in   = grant_last;
               rsp_status_in = (grant_last && granted_next != want_ff)
                               ? oqt_pkg::ST_NOROOM : oqt_pkg::ST_OK;
               if (grant_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in     = IDX_W'(idx_ff + 1'b1);
                  granted_in = granted_next;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         valid_ff        <= '0;
         active_valid_ff <= 1'b0;
         active_slot_ff  <= '0;
         running_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         valid_ff        <= valid_in;
         active_valid_ff <= active_valid_in;
         active_slot_ff  <= active_slot_in;
         running_ff      <= running_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      qid_ff        <= qid_in;
      want_ff       <= want_in;
      samp_ff       <= samp_in;
      idx_ff        <= idx_in;
      granted_ff    <= granted_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_exists_ff <= rsp_exists_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_exists_ff, rsp_value_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> sim/occlusion_query_table_tb.sv
// occlusion_query_table_tb: self-checking bench for the occlusion query slot pool
// directed table then query episodes mixed with noise, checked against a local predictor
// depends on oqt_pkg and occlusion_query_table
module occlusion_query_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS    = oqt_pkg::NUM_SLOTS_DEFAULT;
   localparam int RANDOM_ITEMS = 100;
   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_CYCLES = 400000;
   localparam int N_DIRECTED   = 27;

   // spare command code, ignored by the block
   localparam logic [oqt_pkg::ACTION_W-1:0] ACT_SPARE = 3'd7;

   typedef struct packed {
      logic [oqt_pkg::ACTION_W-1:0] action;
      logic [oqt_pkg::QID_W-1:0]    qid;
      logic [oqt_pkg::COUNT_W-1:0]  count;
      logic [oqt_pkg::SAMPLE_W-1:0] samples;
   } oq_cmd_type;

   typedef struct packed {
      logic [oqt_pkg::QID_W-1:0]    id;
      logic [oqt_pkg::VALUE_W-1:0]  value;
      logic                         exists;
      logic [oqt_pkg::STATUS_W-1:0] status;
      logic                         last;
   } oq_result_type;

   // one directed row; typed rows carry their single expected result
   typedef struct packed {
      logic [oqt_pkg::ACTION_W-1:0] action;
      logic [oqt_pkg::QID_W-1:0]    qid;
      logic [oqt_pkg::COUNT_W-1:0]  count;
      logic [oqt_pkg::SAMPLE_W-1:0] samples;
      logic                         typed;
      logic                         exists;
      logic [oqt_pkg::STATUS_W-1:0] status;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // nothing allocated and no active query after reset
      '{oqt_pkg::ACT_IS_QUERY,   4'd15, 5'd0,  8'd0,   1'b1, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_DELETE,     4'd0,  5'd0,  8'd0,   1'b1, 1'b0, oqt_pkg::ST_UNDEF},
      '{oqt_pkg::ACT_END,        4'd0,  5'd0,  8'd0,   1'b1, 1'b0, oqt_pkg::ST_NOTIN},
      '{oqt_pkg::ACT_GET_RESULT, 4'd15, 5'd0,  8'd0,   1'b1, 1'b0, oqt_pkg::ST_UNDEF},
      '{oqt_pkg::ACT_BEGIN,      4'd7,  5'd0,  8'd0,   1'b1, 1'b0, oqt_pkg::ST_UNDEF},
      '{oqt_pkg::ACT_ALLOC,      4'd0,  5'd0,  8'd0,   1'b1, 1'b0, oqt_pkg::ST_OK},
      '{ACT_SPARE,               4'd15, 5'd31, 8'd255, 1'b1, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_ADD,        4'd0,  5'd0,  8'd255, 1'b1, 1'b0, oqt_pkg::ST_OK},
      // first grant and a full query cycle on slot one
      '{oqt_pkg::ACT_ALLOC,      4'd0,  5'd3,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_BEGIN,      4'd1,  5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_ADD,        4'd1,  5'd0,  8'd255, 1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_ADD,        4'd1,  5'd31, 8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_ADD,        4'd1,  5'd0,  8'd128, 1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_END,        4'd1,  5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_GET_RESULT, 4'd1,  5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      // fill the pool with a shortfall, then ask on a full pool
      '{oqt_pkg::ACT_ALLOC,      4'd0,  5'd16, 8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_ALLOC,      4'd0,  5'd1,  8'd0,   1'b1, 1'b0, oqt_pkg::ST_NOROOM},
      // deleting the active slot ends the query
      '{oqt_pkg::ACT_BEGIN,      4'd15, 5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_DELETE,     4'd15, 5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_END,        4'd15, 5'd0,  8'd0,   1'b1, 1'b0, oqt_pkg::ST_NOTIN},
      // oversized request gets the one hole
      '{oqt_pkg::ACT_DELETE,     4'd2,  5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_ALLOC,      4'd0,  5'd31, 8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      // begin while another query is active
      '{oqt_pkg::ACT_BEGIN,      4'd0,  5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_BEGIN,      4'd2,  5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_ADD,        4'd2,  5'd0,  8'd200, 1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_END,        4'd2,  5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK},
      '{oqt_pkg::ACT_GET_RESULT, 4'd2,  5'd0,  8'd0,   1'b0, 1'b0, oqt_pkg::ST_OK}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;  // query_id[3:0], count[8:4], sample_count[16:9]
   logic [2:0]  req_tuser = '0;  // action[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // result_id[3:0], result_value[35:4], exists[36]
   logic [1:0]  rsp_tuser;       // status[1:0]
   logic        rsp_tlast;

   occlusion_query_table #(.NUM_SLOTS(NUM_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // predictor state
   logic                         pool_valid [NUM_SLOTS];
   logic [oqt_pkg::VALUE_W-1:0]  pool_count [NUM_SLOTS];
   logic                         active_on;
   logic [oqt_pkg::QID_W-1:0]    active_id;
   logic [oqt_pkg::VALUE_W-1:0]  sample_acc;

   oq_result_type pending_results[$];
   int            mismatches = 0;
   int            cycles = 0;
   int            sent_items = 0;
   bit            steady = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // expected results of one command, updates the predictor state
   function automatic void predict_query_results(input oq_cmd_type c,
                                                 ref oq_result_type res[$]);
      oq_result_type r;
      logic          known;
      int            i;
      int            avail;
      int            grant;
      int            n;
      known = (c.qid < NUM_SLOTS) && pool_valid[c.qid];
      r = '0;
      r.last = 1'b1;
      case (c.action)
         oqt_pkg::ACT_ALLOC: begin
            avail = 0;
            for (i = 0; i < NUM_SLOTS && i < oqt_pkg::MAX_IDS; i++)
               if (!pool_valid[i]) avail++;
            grant = (avail < int'(c.count)) ? avail : int'(c.count);
            if (c.count == 0) begin
               res.push_back(r);
            end else if (grant == 0) begin
               r.status = oqt_pkg::ST_NOROOM;
               res.push_back(r);
            end else begin
               n = 0;
               for (i = 0; i < NUM_SLOTS && i < oqt_pkg::MAX_IDS && n < grant; i++) begin
                  if (!pool_valid[i]) begin
                     pool_valid[i] = 1'b1;
                     pool_count[i] = '0;
                     r = '0;
                     r.id = oqt_pkg::QID_W'(i);
                     r.exists = 1'b1;
                     r.last = (n == grant - 1);
                     r.status = (n == grant - 1 && grant < int'(c.count))
                                ? oqt_pkg::ST_NOROOM : oqt_pkg::ST_OK;
                     res.push_back(r);
                     n++;
                  end
               end
            end
         end
         oqt_pkg::ACT_DELETE: begin
            if (!known) begin
               r.status = oqt_pkg::ST_UNDEF;
            end else begin
               if (active_on && active_id == c.qid) begin
                  active_on = 1'b0;
                  active_id = '0;
               end
               pool_valid[c.qid] = 1'b0;
               r.exists = 1'b1;
            end
            res.push_back(r);
         end
         oqt_pkg::ACT_IS_QUERY: begin
            r.exists = known;
            res.push_back(r);
         end
         oqt_pkg::ACT_BEGIN: begin
            sample_acc = '0;
            if (!known) begin
               r.status = oqt_pkg::ST_UNDEF;
            end else begin
               pool_count[c.qid] = '0;
               active_on = 1'b1;
               active_id = c.qid;
               r.exists = 1'b1;
            end
            res.push_back(r);
         end
         oqt_pkg::ACT_END: begin
            r.exists = known;
            if (!active_on) begin
               r.status = oqt_pkg::ST_NOTIN;
            end else begin
               pool_count[active_id] = sample_acc;
               active_on = 1'b0;
               active_id = '0;
            end
            res.push_back(r);
         end
         oqt_pkg::ACT_GET_RESULT: begin
            if (!known) begin
               r.status = oqt_pkg::ST_UNDEF;
            end else begin
               r.value = pool_count[c.qid];
               r.exists = 1'b1;
            end
            res.push_back(r);
         end
         oqt_pkg::ACT_ADD: begin
            sample_acc = sample_acc + oqt_pkg::VALUE_W'(c.samples);
            r.exists = known;
            res.push_back(r);
         end
         default: begin
            res.push_back(r);
         end
      endcase
   endfunction

   // idle cycles before the next command transfer
   function automatic int idle_cycles();
      int r;
      r = int'($urandom_range(0, 99));
      if (steady || r < 50) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 96) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 40));
   endfunction

   // command with every field random
   function automatic oq_cmd_type random_command();
      oq_cmd_type c;
      c.action  = oqt_pkg::ACTION_W'($urandom_range(0, 7));
      c.qid     = oqt_pkg::QID_W'($urandom_range(0, 15));
      c.count   = oqt_pkg::COUNT_W'($urandom_range(0, 31));
      c.samples = oqt_pkg::SAMPLE_W'($urandom_range(0, 255));
      return c;
   endfunction

   // some allocated slot, or -1 when the pool is empty
   function automatic int pick_live_slot();
      int start;
      int k;
      int s;
      start = int'($urandom_range(0, NUM_SLOTS - 1));
      for (k = 0; k < NUM_SLOTS; k++) begin
         s = (start + k) % NUM_SLOTS;
         if (pool_valid[s]) return s;
      end
      return -1;
   endfunction

   // drive one command transfer and record what it should produce
   task automatic send_command(input oq_cmd_type c, input bit typed,
                               input oq_result_type typed_exp);
      int            gap;
      oq_result_type fresh[$];
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.action;
      req_tdata  <= {7'd0, c.samples, c.count, c.qid};
      do @(posedge clock); while (!req_tready);
      predict_query_results(c, fresh);
      if (typed) begin
         pending_results.push_back(typed_exp);
      end else begin
         foreach (fresh[j]) pending_results.push_back(fresh[j]);
      end
      sent_items++;
   endtask

   // stimulus: directed table, then query episodes and noise
   initial begin : stimulus
      oq_cmd_type    c;
      oq_result_type e;
      int            i;
      int            slot;
      for (i = 0; i < NUM_SLOTS; i++) begin
         pool_valid[i] = 1'b0;
         pool_count[i] = '0;
      end
      active_on  = 1'b0;
      active_id  = '0;
      sample_acc = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++) begin
         c.action  = DIRECTED_ROWS[i].action;
         c.qid     = DIRECTED_ROWS[i].qid;
         c.count   = DIRECTED_ROWS[i].count;
         c.samples = DIRECTED_ROWS[i].samples;
         e = '0;
         e.exists = DIRECTED_ROWS[i].exists;
         e.status = DIRECTED_ROWS[i].status;
         e.last   = 1'b1;
         send_command(c, DIRECTED_ROWS[i].typed, e);
      end

      sent_items = 0;
      while (sent_items < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0) begin
            // noise: any command, any content
            send_command(random_command(), 1'b0, '0);
         end else begin
            // well-formed query episode with random content
            slot = pick_live_slot();
            if (slot < 0 || $urandom_range(0, 3) == 0) begin
               c = random_command();
               c.action = oqt_pkg::ACT_ALLOC;
               c.count = ($urandom_range(0, 5) == 0)
                         ? oqt_pkg::COUNT_W'($urandom_range(0, 31))
                         : oqt_pkg::COUNT_W'($urandom_range(1, 3));
               send_command(c, 1'b0, '0);
               slot = pick_live_slot();
            end
            if (slot >= 0) begin
               c = random_command();
               c.action = oqt_pkg::ACT_BEGIN;
               c.qid = oqt_pkg::QID_W'(slot);
               send_command(c, 1'b0, '0);
               repeat ($urandom_range(0, 6)) begin
                  c = random_command();
                  c.action = oqt_pkg::ACT_ADD;
                  send_command(c, 1'b0, '0);
               end
               c = random_command();
               c.action = oqt_pkg::ACT_END;
               send_command(c, 1'b0, '0);
               c = random_command();
               c.action = oqt_pkg::ACT_GET_RESULT;
               c.qid = oqt_pkg::QID_W'(slot);
               send_command(c, 1'b0, '0);
               if ($urandom_range(0, 2) == 0) begin
                  c = random_command();
                  c.action = oqt_pkg::ACT_DELETE;
                  c.qid = oqt_pkg::QID_W'(slot);
                  send_command(c, 1'b0, '0);
               end
            end
         end
      end
      req_tvalid <= 1'b0;

      // drain the result channel
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[occlusion_query_table] OK");
      end else begin
         $display("[occlusion_query_table] ERROR");
      end
      $finish;
   end

   // result side back-pressure: free-running stretches and stalls
   initial begin : rsp_pacing
      int r;
      forever begin
         r = int'($urandom_range(0, 99));
         if (r < 25) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else if (r < 70) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else if (r < 93) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(10, 30)) @(posedge clock);
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : rsp_check
      oq_result_type got;
      oq_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.id     = rsp_tdata[3:0];
         got.value  = rsp_tdata[35:4];
         got.exists = rsp_tdata[36];
         got.status = rsp_tuser;
         got.last   = rsp_tlast;
         if (pending_results.size() == 0) begin
            $error("result transfer with no expectation waiting");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (got.id !== want.id) begin
               $error("result_id: expected %0d, got %0d", want.id, got.id);
               mismatches++;
            end
            if (got.value !== want.value) begin
               $error("result_value: expected %0d, got %0d", want.value, got.value);
               mismatches++;
            end
            if (got.exists !== want.exists) begin
               $error("exists: expected %0d, got %0d", want.exists, got.exists);
               mismatches++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               mismatches++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, got.last);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("[occlusion_query_table] ERROR");
         $finish;
      end
   end

endmodule
